FILE: rtl/sscf_pkg.sv
// ----------------------------------------------------------------------------
// sscf_pkg - shared types and constants for the case-folding substring search
// Command codes, result layout, the cell control bundle and the ASCII fold.
// ----------------------------------------------------------------------------
package sscf_pkg;

   // input command codes (carried on req_tuser)
   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // result field widths
   localparam int START_W    = 24;
   localparam int RSP_DATA_W = 32;

   // ASCII range that folds to lower case
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] FOLD_DELTA = 8'h20;

   // control bundle broadcast from the top level to every cell
   typedef struct packed {
      logic       load;     // write data into the addressed cell
      logic       shift;    // advance the match vector by one text byte
      logic       clear;    // clear the match vector
      logic       fold_en;  // case-insensitive compare
      logic [7:0] data;     // raw byte for pattern load
      logic [7:0] text;     // folded text byte
   } cell_ctl_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + FOLD_DELTA;
      end
      return r;
   endfunction

endpackage

FILE: rtl/sscf_cell.sv
// ----------------------------------------------------------------------------
// sscf_cell - one pattern position of the shift-and match chain
// Holds one pattern byte and one match bit; takes the match bit of its left
// neighbor each text byte.
// ----------------------------------------------------------------------------
module sscf_cell
   import sscf_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int LEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [LEN_W-1:0] wr_idx,
   input  logic [LEN_W-1:0] pat_len,
   input  logic             match_prev,
   output logic             match,
   output logic             hit
);

   logic [7:0] byte_ff;
   logic       match_ff;
   logic       match_in;
   logic       active;
   logic       eq;
   logic       step;

   assign active = pat_len > LEN_W'(INDEX);
   assign eq     = fold_byte(byte_ff, ctl.fold_en) == ctl.text;
   assign step   = active && match_prev && eq;
   // this cell is the final pattern position
   assign hit    = ctl.shift && step && (pat_len == LEN_W'(INDEX + 1));
   assign match  = match_ff;

   always_comb begin
      match_in = match_ff;
      priority if (ctl.clear) begin
         match_in = 1'b0;
      end else if (ctl.shift) begin
         match_in = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   // pattern byte: no reset, only read once written
   always_ff @(posedge clock) begin
      if (ctl.load && wr_idx == LEN_W'(INDEX)) begin
         byte_ff <= ctl.data;
      end
   end

endmodule

FILE: rtl/substring_search_case_fold_top.sv
// ----------------------------------------------------------------------------
// substring_search_case_fold_top - leftmost substring search, shift-and
// A chain of match cells, one per pattern byte, finds the first occurrence
// of a loaded pattern in a byte stream, with optional ASCII case folding.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser=command, tdata=data_byte, tlast=last
//  rsp      out  rsp_tvalid/rsp_tready  tdata={pattern_error, match_start, found}
//  csr      in   csr_wr_en              csr_wr_data=case_insensitive
//
//  One item per cycle while req_tready is high. Every cell updates its
//  match bit in the cycle the text byte is accepted; the result of a last
//  text byte is registered and shows on rsp the next cycle.
//  Reset (synchronous, active high) clears control state and match bits;
//  pattern bytes are not reset.
//  A waiting result holds rsp; req stays ready while the output register is
//  empty or being drained in the same cycle.
//
module substring_search_case_fold_top
   import sscf_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int POS_BITS    = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] command
   input  logic                  req_tlast,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] found, [24:1] match_start,
                                              // [25] pattern_error, rest zero
   // configuration
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int OFF_W = POS_BITS + 1;

   // control registers
   logic                  fold_en_ff;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  complete_ff, complete_in;
   logic                  ovf_ff, ovf_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  found_ff, found_in;
   logic [START_W-1:0]    off_ff, off_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  is_text;
   logic [LEN_W-1:0]      len_base;
   logic                  room;
   logic [LEN_W-1:0]      wr_idx;
   cell_ctl_type          ctl;
   logic [MAX_PATTERN:0]  chain;    // chain[0] feeds the first cell
   logic [MAX_PATTERN-1:0] hits;
   logic                  any_hit;
   logic [OFF_W-1:0]      off_calc;
   logic [OFF_W+START_W-1:0] off_wide;
   logic                  found_new;
   logic [START_W-1:0]    off_new;
   logic                  res_found;
   logic [START_W-1:0]    res_start;
   logic                  res_err;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_text    = req_tuser == CMD_TEXT;

   // a pattern byte after a completed pattern starts over at position 0
   assign len_base = complete_ff ? '0 : len_ff;
   assign room     = len_base < LEN_W'(MAX_PATTERN);
   assign wr_idx   = len_base;

   always_comb begin
      ctl.load    = accept && !is_text && room;
      ctl.shift   = accept && is_text;
      ctl.clear   = accept && (!is_text || req_tlast);
      ctl.fold_en = fold_en_ff;
      ctl.data    = req_tdata;
      ctl.text    = fold_byte(req_tdata, fold_en_ff);
   end

   // match chain
   assign chain[0] = 1'b1;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      sscf_cell #(
         .INDEX (j),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_idx     (wr_idx),
         .pat_len    (len_ff),
         .match_prev (chain[j]),
         .match      (chain[j+1]),
         .hit        (hits[j])
      );
   end

   assign any_hit = |hits;

   // start offset = position + 1 - length, kept modulo the result width
   assign off_calc  = {1'b0, pos_ff} + OFF_W'(1) - OFF_W'(len_ff);
   assign off_wide  = (OFF_W + START_W)'(off_calc);
   assign found_new = found_ff || any_hit;
   assign off_new   = found_ff ? off_ff : off_wide[START_W-1:0];

   always_comb begin
      priority if (ovf_ff) begin
         res_found = 1'b0;
         res_start = '0;
         res_err   = 1'b1;
      end else if (len_ff == '0) begin
         res_found = 1'b1;
         res_start = '0;
         res_err   = 1'b0;
      end else begin
         res_found = found_new;
         res_start = found_new ? off_new : '0;
         res_err   = 1'b0;
      end
   end

   always_comb begin
      len_in       = len_ff;
      complete_in  = complete_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         if (!is_text) begin
            len_in      = room ? LEN_W'(len_base + 1'b1) : len_base;
            ovf_in      = (ovf_ff && !complete_ff) || !room;
            complete_in = req_tlast;
            pos_in      = '0;
            found_in    = 1'b0;
            off_in      = '0;
         end else begin
            complete_in = 1'b1;
            pos_in      = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;
            found_in    = found_new;
            off_in      = off_new;
            if (req_tlast) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_err, res_start, res_found});
               pos_in       = '0;
               found_in     = 1'b0;
               off_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_en_ff   <= 1'b0;
         len_ff       <= '0;
         complete_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fold_en_ff <= csr_wr_data;
         end
         len_ff       <= len_in;
         complete_ff  <= complete_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_rsp_from_text_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && is_text && req_tlast))
      else $error("result without a last text item");

   a_err_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[START_W+1] |-> !rsp_data_ff[0] &&
         rsp_data_ff[START_W:1] == '0)
      else $error("pattern error result reports a match");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> len_ff == LEN_W'(MAX_PATTERN))
      else $error("overflow flag with pattern not full");

   a_found_needs_pattern: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> len_ff != '0)
      else $error("match recorded with empty pattern");

endmodule
